// File: rtl/btpc_pkg.sv
// ============================================================================
// btpc_pkg
// Shared widths, register indexes and stage payload types for the
// barometric temperature and pressure compensation pipeline.
// ============================================================================
package btpc_pkg;

  localparam int unsigned AdcW  = 20;
  localparam int unsigned DivW  = 32;
  localparam int unsigned AddrW = 5;

  typedef enum logic [1:0] {
    REG_CAL_TEMP   = 2'd0,
    REG_CAL_PRESSA = 2'd1,
    REG_CAL_PRESSB = 2'd2,
    REG_CAL_P9     = 2'd3
  } reg_idx_e;

  localparam logic [31:0] FineOffset = 32'd64000;
  localparam logic [31:0] P1Bias     = 32'd32768;
  localparam logic [31:0] AdcFull    = 32'd1048576;
  localparam logic [31:0] PressScale = 32'd3125;
  localparam logic [31:0] RoundHalf  = 32'd128;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  // Payload entering the divider from the front stages.
  typedef struct packed {
    logic [31:0] fine;
    logic [15:0] tcent;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic        big;
    logic        invalid;
  } div_req_t;

  typedef struct packed {
    logic [31:0] fine;
    logic [15:0] tcent;
    logic [31:0] quot;
    logic        invalid;
  } div_rsp_t;

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

// File: rtl/btpc_regs.sv
// ============================================================================
// btpc_regs
// APB calibration register file; presents the decoded calibration words.
// ============================================================================
module btpc_regs import btpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output cal_t             cal_o
);

  logic [47:0] temp_q;
  logic [63:0] pa_q;
  logic [63:0] pb_q;
  logic [15:0] p9_q;
  logic        wr_en;
  logic [1:0]  idx;
  logic        in_range;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite;
  assign idx      = paddr[4:3];
  assign in_range = (paddr[2:0] == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      p9_q   <= '0;
    end else if (wr_en && in_range) begin
      case (reg_idx_e'(idx))
        REG_CAL_TEMP:   temp_q <= pwdata[47:0];
        REG_CAL_PRESSA: pa_q   <= pwdata;
        REG_CAL_PRESSB: pb_q   <= pwdata;
        REG_CAL_P9:     p9_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (in_range) begin
      case (reg_idx_e'(idx))
        REG_CAL_TEMP:   prdata = {16'd0, temp_q};
        REG_CAL_PRESSA: prdata = pa_q;
        REG_CAL_PRESSB: prdata = pb_q;
        REG_CAL_P9:     prdata = {48'd0, p9_q};
        default:        prdata = '0;
      endcase
    end
  end

  assign cal_o = '{t1: temp_q[15:0], t2: temp_q[31:16], t3: temp_q[47:32],
                   p1: pa_q[15:0], p2: pa_q[31:16], p3: pa_q[47:32], p4: pa_q[63:48],
                   p5: pb_q[15:0], p6: pb_q[31:16], p7: pb_q[47:32], p8: pb_q[63:48],
                   p9: p9_q};

endmodule

// File: rtl/btpc_front.sv
// ============================================================================
// btpc_front
// Temperature compensation and pressure pre-divide terms, eight stages.
// ============================================================================
module btpc_front import btpc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  logic [AdcW-1:0] adc_t_i,
  input  logic [AdcW-1:0] adc_p_i,
  input  cal_t            cal_i,
  output logic            valid_o,
  output div_req_t        req_o
);

  logic [4:0] v_q;

  // stage 1
  logic [31:0] s1_x_q, s1_d_q;
  logic [AdcW-1:0] s1_p_q;
  // stage 2
  logic [31:0] s2_a_q, s2_dd_q;
  logic [AdcW-1:0] s2_p_q;
  // stage 3
  logic [31:0] s3_a_q, s3_b_q;
  logic [AdcW-1:0] s3_p_q;
  // stage 4: fine, temperature, pressure parts
  logic [31:0] s4_fine_q, s4_f5_q, s4_pa_q;
  logic [AdcW-1:0] s4_p_q;
  // stage 5: products
  logic [31:0] s5_fine_q, s5_pa_q, s5_sq_q, s5_ap5_q, s5_ap2_q;
  logic [15:0] s5_tc_q;
  logic [AdcW-1:0] s5_p_q;
  // stage 6
  logic [31:0] s6_fine_q, s6_b_q, s6_ax_q;
  logic [15:0] s6_tc_q;
  logic [AdcW-1:0] s6_p_q;
  // stage 7
  logic [31:0] s7_fine_q, s7_b_q, s7_ap1_q;
  logic [15:0] s7_tc_q;
  logic [AdcW-1:0] s7_p_q;

  logic [31:0] tcv, fine_c, pa_c, b6, ax6, sq6;
  logic [15:0] tsat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv_i) v_q <= {v_q[3:0], valid_i};
  end
  logic v6_q, v7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv_i) begin
      v6_q <= v_q[4];
      v7_q <= v6_q;
    end
  end

  assign fine_c = s3_a_q + s3_b_q;
  assign tcv    = asr32(s4_f5_q + RoundHalf, 8);
  always_comb begin
    if (!tcv[31] && tcv[30:15] != 16'd0) tsat = 16'h7fff;
    else if (tcv[31] && tcv[30:15] != 16'hffff) tsat = 16'h8000;
    else tsat = tcv[15:0];
  end
  assign pa_c = asr32(fine_c, 1) - FineOffset;
  assign sq6  = s5_sq_q;
  assign b6   = asr32(sq6, 11);
  assign ax6  = asr32(sq6, 13);

  logic [31:0] s6_ap2_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_x_q  <= {15'd0, adc_t_i[19:3]} - {15'd0, cal_i.t1, 1'b0};
      s1_d_q  <= {16'd0, adc_t_i[19:4]} - {16'd0, cal_i.t1};
      s1_p_q  <= adc_p_i;
      s2_a_q  <= asr32(s1_x_q * sx16(cal_i.t2), 11);
      s2_dd_q <= asr32(s1_d_q * s1_d_q, 12);
      s2_p_q  <= s1_p_q;
      s3_a_q  <= s2_a_q;
      s3_b_q  <= asr32(s2_dd_q * sx16(cal_i.t3), 14);
      s3_p_q  <= s2_p_q;
      s4_fine_q <= fine_c;
      s4_f5_q   <= fine_c * 32'd5;
      s4_pa_q   <= pa_c;
      s4_p_q    <= s3_p_q;
      s5_fine_q <= s4_fine_q;
      s5_tc_q   <= tsat;
      s5_pa_q   <= s4_pa_q;
      s5_sq_q   <= asr32(s4_pa_q, 2) * asr32(s4_pa_q, 2);
      s5_ap5_q  <= s4_pa_q * sx16(cal_i.p5);
      s5_ap2_q  <= s4_pa_q * sx16(cal_i.p2);
      s5_p_q    <= s4_p_q;
      s6_fine_q <= s5_fine_q;
      s6_tc_q   <= s5_tc_q;
      s6_b_q    <= asr32(b6 * sx16(cal_i.p6) + {s5_ap5_q[30:0], 1'b0}, 2)
                   + {cal_i.p4, 16'd0};
      s6_ax_q   <= sx16(cal_i.p3) * ax6;
      s6_ap2_q  <= s5_ap2_q;
      s6_p_q    <= s5_p_q;
      s7_fine_q <= s6_fine_q;
      s7_tc_q   <= s6_tc_q;
      s7_b_q    <= s6_b_q;
      s7_ap1_q  <= P1Bias + asr32(asr32(s6_ax_q, 3) + asr32(s6_ap2_q, 1), 18);
      s7_p_q    <= s6_p_q;
    end
  end

  // stage 8 output: divisor, dividend, branch
  logic [31:0] dv_c, pr_c;
  assign dv_c = asr32(s7_ap1_q * {16'd0, cal_i.p1}, 15);
  assign pr_c = ((AdcFull - {12'd0, s7_p_q}) - asr32(s7_b_q, 12)) * PressScale;
  logic v8_q;
  div_req_t r8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (adv_i) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r8_q.fine     <= s7_fine_q;
      r8_q.tcent    <= s7_tc_q;
      r8_q.divisor  <= dv_c;
      r8_q.big      <= pr_c[31];
      r8_q.dividend <= pr_c[31] ? pr_c : {pr_c[30:0], 1'b0};
      r8_q.invalid  <= (dv_c == 32'd0);
    end
  end

  assign valid_o = v8_q;
  assign req_o   = r8_q;

endmodule

// File: rtl/btpc_div.sv
// ============================================================================
// btpc_div
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ============================================================================
module btpc_div import btpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  div_req_t req_i,
  output logic     valid_o,
  output div_rsp_t rsp_o
);

  logic [DivW:0]    v_q;
  div_req_t         r_q   [DivW+1];
  logic [DivW-1:0]  rem_q [DivW+1];
  logic [DivW-1:0]  quo_q [DivW+1];

  always_comb begin
    v_q[0]   = valid_i;
    r_q[0]   = req_i;
    rem_q[0] = '0;
    quo_q[0] = req_i.dividend;
  end

  for (genvar i = 0; i < DivW; i++) begin : g_st
    logic [DivW:0] trial;
    logic [DivW:0] sh;
    assign sh    = {rem_q[i], quo_q[i][DivW-1]};
    assign trial = sh - {1'b0, r_q[i].divisor};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (adv_i) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q[i+1]   <= r_q[i];
        rem_q[i+1] <= trial[DivW] ? sh[DivW-1:0] : trial[DivW-1:0];
        quo_q[i+1] <= {quo_q[i][DivW-2:0], ~trial[DivW]};
      end
    end
  end

  assign valid_o        = v_q[DivW];
  assign rsp_o.fine     = r_q[DivW].fine;
  assign rsp_o.tcent    = r_q[DivW].tcent;
  assign rsp_o.invalid  = r_q[DivW].invalid;
  assign rsp_o.quot     = r_q[DivW].big ? {quo_q[DivW][30:0], 1'b0} : quo_q[DivW];

endmodule

// File: rtl/btpc_back.sv
// ============================================================================
// btpc_back
// Post-divide pressure correction, three stages, the last one the output
// register.
// ============================================================================
module btpc_back import btpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  div_rsp_t rsp_i,
  input  cal_t     cal_i,
  output logic     valid_o,
  output logic [31:0] fine_o,
  output logic [15:0] tc_o,
  output logic [31:0] p_o,
  output logic        inv_o
);

  logic [2:0]  v_q;
  logic [31:0] f_q [3];
  logic [15:0] t_q [3];
  logic [2:0]  i_q;
  logic [31:0] p1_q, sq_q, b_q;
  logic [31:0] p2_q, a_q, b2_q;
  logic [31:0] p3_q;
  logic [31:0] p_sh3;

  assign p_sh3 = {3'd0, rsp_i.quot[31:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv_i) v_q <= {v_q[1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f_q[0] <= rsp_i.fine;  t_q[0] <= rsp_i.tcent; i_q[0] <= rsp_i.invalid;
      p1_q   <= rsp_i.quot;
      sq_q   <= (p_sh3 * p_sh3) >> 13;
      b_q    <= asr32({2'd0, rsp_i.quot[31:2]} * sx16(cal_i.p8), 13);
      f_q[1] <= f_q[0];      t_q[1] <= t_q[0];      i_q[1] <= i_q[0];
      p2_q   <= p1_q;
      a_q    <= asr32(sx16(cal_i.p9) * sq_q, 12);
      b2_q   <= b_q;
      f_q[2] <= f_q[1];      t_q[2] <= t_q[1];      i_q[2] <= i_q[1];
      p3_q   <= i_q[1] ? 32'd0 : p2_q + asr32(a_q + b2_q + sx16(cal_i.p7), 4);
    end
  end

  assign valid_o = v_q[2];
  assign fine_o  = f_q[2];
  assign tc_o    = t_q[2];
  assign p_o     = p3_q;
  assign inv_o   = i_q[2];

endmodule

// File: rtl/baro_temp_pressure_compensate_unit.sv
// ============================================================================
// baro_temp_pressure_compensate_unit
// Integer barometric temperature and pressure compensation pipeline.
// ============================================================================
// Usage:
//   Input channel: adc_temperature_i and adc_pressure_i with valid_i; an item
//   is accepted when valid_i is high and stall_o is low.
//   Output channel: fine_temperature_o, temperature_centi_o, pressure_pa_o,
//   pressure_invalid_o with valid_o; taken when valid_o is high and stall_i
//   is low.
//   Calibration is written over the APB port at byte addresses 0, 8, 16, 24
//   (64-bit data) while the pipeline is empty.
//   Throughput: one item per cycle while stall_i does not hold the pipeline.
//   Stages from acceptance to valid_o: 8 front stages, 32 divider stages
//   (one quotient bit each), and 3 correction stages.
//   The whole pipeline advances as one; when stall_i is high and an item
//   sits in the output stage, every stage holds and stall_o is raised.
//   Empty slots are not squeezed out; stall_o rises only when the output
//   stage holds an untaken item.
//   Reset clears all valid bits and calibration registers to zero.
// ============================================================================
module baro_temp_pressure_compensate_unit import btpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [AdcW-1:0]  adc_temperature_i,
  input  logic [AdcW-1:0]  adc_pressure_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [31:0]      fine_temperature_o,
  output logic [15:0]      temperature_centi_o,
  output logic [31:0]      pressure_pa_o,
  output logic             pressure_invalid_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  cal_t     cal;
  logic     adv;
  logic     f_v, d_v;
  div_req_t req;
  div_rsp_t rsp;

  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  btpc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cal_o(cal)
  );

  btpc_front u_front (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(valid_i),
    .adc_t_i(adc_temperature_i), .adc_p_i(adc_pressure_i), .cal_i(cal),
    .valid_o(f_v), .req_o(req)
  );

  btpc_div u_div (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(f_v), .req_i(req),
    .valid_o(d_v), .rsp_o(rsp)
  );

  btpc_back u_back (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(d_v), .rsp_i(rsp), .cal_i(cal),
    .valid_o(valid_o), .fine_o(fine_temperature_o), .tc_o(temperature_centi_o),
    .p_o(pressure_pa_o), .inv_o(pressure_invalid_o)
  );

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(pressure_pa_o)
                           && $stable(fine_temperature_o))
    else $error("output item changed under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("stall raised without blocked output");
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && pressure_invalid_o |-> pressure_pa_o == 32'd0)
    else $error("invalid pressure not zero");

endmodule
